/* hw/rtl/kmpq_pkg.sv */
// ----------------------------------------------------------------------------
// kmpq_pkg
// Shared constants and types for the keyed minimum-priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kmpq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;

  // Stored key width: the key port is 32 bits wide.
  localparam int KEY_W   = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int STAMP_W = 64;
  localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    STATUS_ADDED     = 3'd0,
    STATUS_LOWERED   = 3'd1,
    STATUS_UNCHANGED = 3'd2,
    STATUS_POPPED    = 3'd3,
    STATUS_FULL      = 3'd4,
    STATUS_EMPTY     = 3'd5
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Sequencer to scan unit.
  typedef struct packed {
    logic             start;
    logic             find_min;  // 0: key search, 1: earliest-stamp search
    logic [CNT_W-1:0] limit;     // number of slots to visit
  } scan_ctrl_t;

  // Scan unit to sequencer; all fields but done hold after done until the next start.
  typedef struct packed {
    logic               done;
    logic               found;
    logic               lower;   // key search: new stamp is earlier than stored
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } scan_res_t;

endpackage

`default_nettype wire

/* hw/rtl/keyed_min_priority_queue.sv */
// ----------------------------------------------------------------------------
// keyed_min_priority_queue
// Min-priority queue of (key, stamp) entries, one entry per key, with
// add-or-lower and pop-earliest operations over a slot memory.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+---------------------------------------
//  in       | in_valid_i / in_ready_o  | opcode_i, key_i, stamp_i
//  out      | out_valid_o / out_ready_i| status_o, removed_key_o,
//           |                          | removed_stamp_o, head_valid_o,
//           |                          | head_key_o, head_stamp_o, occupancy_o
//
//  The result of an add or a pop is loaded onto out in the cycle that
//  in_ready_o rises. One scan through the memory's single read port finds
//  the key or the earliest entry, a pop then moves the last entry into the
//  freed slot (S_MOVE_RD reads it, S_MOVE_WR writes it), and a final scan
//  finds the new head.
//  Reset clears state, entry count and out_valid; slot memory is not cleared.
//  A new item is taken while the previous result still waits on out; the
//  block stalls only at the end of an item if that result is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_min_priority_queue import kmpq_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         opcode_i,
  input  wire logic [31:0]  key_i,
  input  wire logic [63:0]  stamp_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [2:0]        status_o,
  output logic [31:0]       removed_key_o,
  output logic [63:0]       removed_stamp_o,
  output logic              head_valid_o,
  output logic [31:0]       head_key_o,
  output logic [63:0]       head_stamp_o,
  output logic [4:0]        occupancy_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FIND    = 3'd1;
  localparam logic [2:0] S_PICK    = 3'd2;
  localparam logic [2:0] S_MOVE_RD = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;
  localparam logic [2:0] S_HEAD    = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  localparam logic OP_ADD = 1'b0;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   count_m1;
  logic [KEY_W-1:0]   key_q;
  logic [STAMP_W-1:0] stamp_q;
  status_e            status_q, status_d;
  logic [KEY_W-1:0]   rem_key_q, rem_key_d;
  logic [STAMP_W-1:0] rem_stamp_q, rem_stamp_d;
  logic               in_xfer;

  logic               out_valid_q, out_valid_d;
  logic [2:0]         out_status_q;
  logic [31:0]        out_rem_key_q;
  logic [63:0]        out_rem_stamp_q;
  logic               out_head_valid_q;
  logic [31:0]        out_head_key_q;
  logic [63:0]        out_head_stamp_q;
  logic [4:0]         out_occ_q;
  logic               out_load;

  entry_t             mem_q [CAPACITY];
  entry_t             rd_q;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  entry_t             mem_wdata;
  logic [SLOT_W-1:0]  mem_raddr;
  logic [SLOT_W-1:0]  scan_raddr;

  scan_ctrl_t         scan_ctrl;
  scan_res_t          scan_res;

  kmpq_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .key_i     (key_q),
    .stamp_i   (stamp_q),
    .rd_data_i (rd_q),
    .rd_addr_o (scan_raddr),
    .res_o     (scan_res)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign count_m1   = count_q - CNT_W'(1);
  assign mem_raddr  = (state_q == S_MOVE_RD) ? count_m1[SLOT_W-1:0] : scan_raddr;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    rem_key_d   = rem_key_q;
    rem_stamp_d = rem_stamp_q;
    mem_we      = 1'b0;
    mem_waddr   = scan_res.slot;
    mem_wdata   = '{key: key_q, stamp: stamp_q};
    scan_ctrl   = '{start: 1'b0, find_min: 1'b0, limit: count_q};
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          rem_key_d   = '0;
          rem_stamp_d = '0;
          scan_ctrl.start = 1'b1;
          if (opcode_i == OP_ADD) begin
            state_d = S_FIND;
          end else if (count_q == '0) begin
            status_d = STATUS_EMPTY;
            scan_ctrl.find_min = 1'b1;
            state_d = S_HEAD;
          end else begin
            scan_ctrl.find_min = 1'b1;
            state_d = S_PICK;
          end
        end
      end
      S_FIND: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            if (scan_res.lower) begin
              mem_we   = 1'b1;
              status_d = STATUS_LOWERED;
            end else begin
              status_d = STATUS_UNCHANGED;
            end
          end else if (count_q == CNT_W'(CAPACITY)) begin
            status_d = STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count_q[SLOT_W-1:0];
            count_d   = count_q + CNT_W'(1);
            status_d  = STATUS_ADDED;
          end
          scan_ctrl = '{start: 1'b1, find_min: 1'b1, limit: count_d};
          state_d   = S_HEAD;
        end
      end
      S_PICK: begin
        if (scan_res.done) begin
          rem_key_d   = scan_res.key;
          rem_stamp_d = scan_res.stamp;
          state_d     = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        // Last occupied slot is read this cycle.
        state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        // Move the last entry into the freed slot.
        mem_we    = 1'b1;
        mem_wdata = rd_q;
        count_d   = count_m1;
        status_d  = STATUS_POPPED;
        scan_ctrl = '{start: 1'b1, find_min: 1'b1, limit: count_m1};
        state_d   = S_HEAD;
      end
      S_HEAD: begin
        if (scan_res.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the previous result has been taken.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q   <= key_i[KEY_W-1:0];
      stamp_q <= stamp_i;
    end
    status_q    <= status_d;
    rem_key_q   <= rem_key_d;
    rem_stamp_q <= rem_stamp_d;
    if (out_load) begin
      out_status_q     <= status_q;
      out_rem_key_q    <= 32'(rem_key_q);
      out_rem_stamp_q  <= rem_stamp_q;
      out_head_valid_q <= scan_res.found;
      out_head_key_q   <= scan_res.found ? 32'(scan_res.key) : 32'd0;
      out_head_stamp_q <= scan_res.found ? scan_res.stamp : 64'd0;
      out_occ_q        <= 5'(count_q);
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_key_o   = out_rem_key_q;
  assign removed_stamp_o = out_rem_stamp_q;
  assign head_valid_o    = out_head_valid_q;
  assign head_key_o      = out_head_key_q;
  assign head_stamp_o    = out_head_stamp_q;
  assign occupancy_o     = out_occ_q;

endmodule

`default_nettype wire

/* hw/rtl/kmpq_scan.sv */
// ----------------------------------------------------------------------------
// kmpq_scan
// Pass over the occupied slots with one shared 64-bit stamp comparator: either
// find a key or find the earliest stamp (lowest slot wins ties).
// ----------------------------------------------------------------------------
`default_nettype none

module kmpq_scan import kmpq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire scan_ctrl_t         ctrl_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [STAMP_W-1:0] stamp_i,
  input  wire entry_t             rd_data_i,
  output logic [SLOT_W-1:0]       rd_addr_o,
  output scan_res_t               res_o
);

  logic               busy_q, busy_d;
  logic               min_q, min_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic [CNT_W-1:0]   limit_q, limit_d;
  logic               pv_q, pv_d;
  logic [SLOT_W-1:0]  pidx_q, pidx_d;
  logic               found_q, found_d;
  logic               lower_q, lower_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;

  logic               done;
  logic [STAMP_W-1:0] cmp_a, cmp_b;
  logic               cmp_lt;

  // Shared comparator: key search asks new < stored, min search stored < best.
  assign cmp_a  = min_q ? rd_data_i.stamp : stamp_i;
  assign cmp_b  = min_q ? stamp_q : rd_data_i.stamp;
  assign cmp_lt = cmp_a < cmp_b;

  assign done      = busy_q && (issue_q >= limit_q) && !pv_q;
  assign rd_addr_o = issue_q[SLOT_W-1:0];

  always_comb begin
    busy_d  = busy_q;
    min_d   = min_q;
    issue_d = issue_q;
    limit_d = limit_q;
    pv_d    = pv_q;
    pidx_d  = pidx_q;
    found_d = found_q;
    lower_d = lower_q;
    slot_d  = slot_q;
    key_d   = key_q;
    stamp_d = stamp_q;
    if (ctrl_i.start) begin
      busy_d  = 1'b1;
      min_d   = ctrl_i.find_min;
      issue_d = '0;
      limit_d = ctrl_i.limit;
      pv_d    = 1'b0;
      found_d = 1'b0;
      lower_d = 1'b0;
    end else if (busy_q) begin
      if (issue_q < limit_q) begin
        issue_d = issue_q + CNT_W'(1);
        pv_d    = 1'b1;
        pidx_d  = issue_q[SLOT_W-1:0];
      end else begin
        pv_d = 1'b0;
      end
      if (pv_q) begin
        if (min_q) begin
          if (!found_q || cmp_lt) begin
            found_d = 1'b1;
            slot_d  = pidx_q;
            key_d   = rd_data_i.key;
            stamp_d = rd_data_i.stamp;
          end
        end else if (!found_q && (rd_data_i.key == key_i)) begin
          found_d = 1'b1;
          lower_d = cmp_lt;
          slot_d  = pidx_q;
        end
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      min_q   <= 1'b0;
      issue_q <= '0;
      limit_q <= '0;
      pv_q    <= 1'b0;
      found_q <= 1'b0;
      lower_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      min_q   <= min_d;
      issue_q <= issue_d;
      limit_q <= limit_d;
      pv_q    <= pv_d;
      found_q <= found_d;
      lower_q <= lower_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    slot_q  <= slot_d;
    key_q   <= key_d;
    stamp_q <= stamp_d;
  end

  always_comb begin
    res_o.done  = done;
    res_o.found = found_q;
    res_o.lower = lower_q;
    res_o.slot  = slot_q;
    res_o.key   = key_q;
    res_o.stamp = stamp_q;
  end

endmodule

`default_nettype wire
